@@ hw/rtl/cpml_pkg.sv @@
// Package for the CIGAR parse-and-merge core: count width, character codes,
// the result record, the saturating add and the class helper.
// No dependencies.
package cpml_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned OutWidth   = 32;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [OutWidth-1:0]   total_t;

  localparam count_t CountMax = '1;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChA    = 8'h41;
  localparam logic [7:0] ChC    = 8'h43;
  localparam logic [7:0] ChD    = 8'h44;
  localparam logic [7:0] ChG    = 8'h47;
  localparam logic [7:0] ChI    = 8'h49;
  localparam logic [7:0] ChM    = 8'h4D;
  localparam logic [7:0] ChT    = 8'h54;

  typedef struct packed {
    logic       final_result;
    total_t     ins_total;
    total_t     read_total;
    total_t     ref_total;
    total_t     run_count;
    logic [7:0] op_code;
  } result_t;

  function automatic count_t sat_add(count_t a, count_t b);
    logic [CountWidth:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CountWidth] ? CountMax : sum[CountWidth-1:0];
  endfunction

  // Base letters all belong to the match class.
  function automatic logic [7:0] op_class(logic [7:0] c);
    if (c == ChA || c == ChC || c == ChG || c == ChT) begin
      return ChM;
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/cigar_parse_merge_lengths_core.sv @@
// CIGAR string parser: builds counts from digits, merges adjacent runs of the
// same class and keeps reference, read and insert length totals.
// Depends on cpml_pkg.
//
// Usage:
//   The string arrives on the slave stream one character per word; tdata is
//   the character and tlast marks the final character of the string.
//   Each closed run leaves on the master stream as one word; the word that
//   carries tlast is the last result of the string and holds exact totals.
//   An empty string (or one with digits only) gives a single tlast word with
//   op_code 0 and run_count 0.
// Timing:
//   A character is held in the input register after it is accepted and is
//   processed from there once the queue has room; its results enter a
//   four-word output queue at the end of that cycle and are offered from the
//   queue. One character is taken per cycle while the queue has room.
//   A character makes at most two result words, and the output port drains
//   one per cycle, so sustained input rate is bounded by the output side:
//   the input register holds while the queue has fewer than two free slots.
// Reset:
//   Clears the count, the pending run, the totals and the output queue.
// Stall:
//   When the receiver holds tready low, the queue fills, the input register
//   holds its character and tready on the slave side drops. No word is lost.
module cigar_parse_merge_lengths_core
  import cpml_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  input  logic         s_axis_tlast,   // end_of_string
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] op_code, [39:8] run_count, [71:40] ref_total, [103:72] read_total,
  // [135:104] ins_total
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast    // final_result
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  // Parser state.
  count_t     acc_q, acc_d;
  logic [7:0] pend_op_q, pend_op_d;
  count_t     pend_count_q, pend_count_d;
  logic       pend_valid_q, pend_valid_d;
  count_t     ref_q, ref_d;
  count_t     read_q, read_d;
  count_t     ins_q, ins_d;

  // Output queue.
  result_t             fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   fill_q, fill_d;

  logic                  proceed;
  logic                  is_digit;
  logic [CountWidth+3:0] dig_ext;
  logic [3:0]            dig_val;
  logic [7:0]            cls;
  count_t                op_cnt;
  logic                  emit_mid;
  result_t               mid_res, fin_res, ent0, ent1;
  logic [1:0]            push_n;
  logic                  pop;

  assign proceed       = in_valid_q &&
                         (fill_q <= (FifoPtrW+1)'(FifoDepth - 2));
  assign s_axis_tready = !in_valid_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign is_digit = (in_ch_q >= ChZero) && (in_ch_q <= ChNine);
  assign dig_val  = 4'(in_ch_q - ChZero);
  // acc * 10 + digit; it overflows exactly when it passes the count maximum.
  assign dig_ext  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                    (CountWidth+4)'(dig_val);
  assign cls      = op_class(in_ch_q);
  assign op_cnt   = (acc_q == '0) ? count_t'(1) : acc_q;

  always_comb begin
    acc_d        = acc_q;
    pend_op_d    = pend_op_q;
    pend_count_d = pend_count_q;
    pend_valid_d = pend_valid_q;
    ref_d        = ref_q;
    read_d       = read_q;
    ins_d        = ins_q;
    emit_mid     = 1'b0;

    if (is_digit) begin
      acc_d = (dig_ext > {4'b0, CountMax}) ? CountMax : dig_ext[CountWidth-1:0];
    end else begin
      acc_d = '0;
      if (cls == ChM || in_ch_q == ChD) begin
        ref_d = sat_add(ref_q, op_cnt);
      end
      if (in_ch_q != ChD) begin
        read_d = sat_add(read_q, op_cnt);
      end
      if (in_ch_q == ChI) begin
        ins_d = sat_add(ins_q, op_cnt);
      end
      if (pend_valid_q && op_class(pend_op_q) == cls) begin
        pend_count_d = sat_add(pend_count_q, op_cnt);
        if (cls == ChM) begin
          pend_op_d = ChM;
        end
      end else begin
        emit_mid     = pend_valid_q;
        pend_op_d    = in_ch_q;
        pend_count_d = op_cnt;
        pend_valid_d = 1'b1;
      end
    end

    // Both results of a character carry the totals after this character.
    mid_res.op_code      = pend_op_q;
    mid_res.run_count    = OutWidth'(pend_count_q);
    mid_res.ref_total    = OutWidth'(ref_d);
    mid_res.read_total   = OutWidth'(read_d);
    mid_res.ins_total    = OutWidth'(ins_d);
    mid_res.final_result = 1'b0;

    fin_res              = mid_res;
    fin_res.op_code      = pend_valid_d ? pend_op_d : 8'h00;
    fin_res.run_count    = pend_valid_d ? OutWidth'(pend_count_d) : '0;
    fin_res.final_result = 1'b1;

    if (in_last_q) begin
      acc_d        = '0;
      pend_op_d    = '0;
      pend_count_d = '0;
      pend_valid_d = 1'b0;
      ref_d        = '0;
      read_d       = '0;
      ins_d        = '0;
    end
  end

  assign ent0   = emit_mid ? mid_res : fin_res;
  assign ent1   = fin_res;
  assign push_n = proceed ? (2'(emit_mid) + 2'(in_last_q)) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      pend_op_q    <= '0;
      pend_count_q <= '0;
      pend_valid_q <= 1'b0;
      ref_q        <= '0;
      read_q       <= '0;
      ins_q        <= '0;
    end else if (proceed) begin
      acc_q        <= acc_d;
      pend_op_q    <= pend_op_d;
      pend_count_q <= pend_count_d;
      pend_valid_q <= pend_valid_d;
      ref_q        <= ref_d;
      read_q       <= read_d;
      ins_q        <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= ent0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + FifoPtrW'(1)] <= ent1;
    end
  end

  assign m_axis_tvalid = (fill_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign fill_d        = fill_q + (FifoPtrW+1)'(push_n) - (FifoPtrW+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop);
      fill_q   <= fill_d;
    end
  end

  assign m_axis_tdata = {fifo_q[rd_ptr_q].ins_total, fifo_q[rd_ptr_q].read_total,
                         fifo_q[rd_ptr_q].ref_total, fifo_q[rd_ptr_q].run_count,
                         fifo_q[rd_ptr_q].op_code};
  assign m_axis_tlast = fifo_q[rd_ptr_q].final_result;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (FifoPtrW+1)'(FifoDepth))
    else $error("output queue overfilled");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed && in_last_q |=> !pend_valid_q && acc_q == '0 && ref_q == '0)
    else $error("state not cleared after end of string");

  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_valid_q |-> pend_count_q == '0 && pend_op_q == '0)
    else $error("pending run data without a pending run");

  a_op_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed && !is_digit |=> acc_q == '0)
    else $error("digit count survived an operation letter");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for cigar_parse_merge_lengths_core: random and
// directed CIGAR strings in, merged runs and length totals checked out.
// Depends on cpml_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import cpml_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } char_word_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;   // [7:0] ch
  logic         s_axis_tlast  = 1'b0; // end_of_string
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [7:0] op_code, [39:8] run_count, [71:40] ref_total, [103:72] read_total,
  // [135:104] ins_total
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;         // final_result

  char_word_t pending_chars[$];
  result_t    expected_runs[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int mismatches   = 0;

  // Parser state mirrored from the block's behavior.
  count_t     digits_val;
  logic [7:0] open_op;
  count_t     open_len;
  logic       open_run;
  count_t     sum_ref;
  count_t     sum_read;
  count_t     sum_ins;

  cigar_parse_merge_lengths_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic count_t add_clamped(count_t a, count_t b);
    logic [CountWidth:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CountWidth] ? CountMax : sum[CountWidth-1:0];
  endfunction

  function automatic logic [7:0] letter_class(logic [7:0] c);
    return (c == ChA || c == ChC || c == ChG || c == ChT) ? ChM : c;
  endfunction

  function automatic void note_run(logic [7:0] op, count_t len, logic last);
    result_t r;
    r.op_code      = op;
    r.run_count    = len;
    r.ref_total    = sum_ref;
    r.read_total   = sum_read;
    r.ins_total    = sum_ins;
    r.final_result = last;
    expected_runs.insert(expected_runs.size(), r);
  endfunction

  function automatic void clear_parser();
    digits_val = '0;
    open_op    = '0;
    open_len   = '0;
    open_run   = 1'b0;
    sum_ref    = '0;
    sum_read   = '0;
    sum_ins    = '0;
  endfunction

  function automatic void parse_char(logic [7:0] c, logic eos);
    logic [63:0] grown;
    count_t      len;
    logic [7:0]  cls;
    if (c >= ChZero && c <= ChNine) begin
      grown = {32'b0, digits_val} * 64'd10 + {56'b0, c - ChZero};
      digits_val = (grown > {32'b0, CountMax}) ? CountMax : grown[CountWidth-1:0];
    end else begin
      len = (digits_val == '0) ? count_t'(1) : digits_val;
      cls = letter_class(c);
      digits_val = '0;
      if (cls == ChM || c == ChD) sum_ref = add_clamped(sum_ref, len);
      if (c != ChD) sum_read = add_clamped(sum_read, len);
      if (c == ChI) sum_ins = add_clamped(sum_ins, len);
      if (open_run && letter_class(open_op) == cls) begin
        open_len = add_clamped(open_len, len);
        if (cls == ChM) open_op = ChM;
      end else begin
        if (open_run) note_run(open_op, open_len, 1'b0);
        open_op  = c;
        open_len = len;
        open_run = 1'b1;
      end
    end
    if (eos) begin
      if (open_run) note_run(open_op, open_len, 1'b1);
      else note_run(8'h00, '0, 1'b1);
      clear_parser();
    end
  endfunction

  // Character driver.
  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    char_word_t nxt;
    logic       busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      clear_parser();
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, s_axis_tlast);
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = pending_chars.pop_front();
          s_axis_tdata  <= nxt.ch;
          s_axis_tlast  <= nxt.eos;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : watch_runs
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata};
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: %h", got);
        end else begin
          want = expected_runs.pop_front();
          if (got.op_code !== want.op_code || got.run_count !== want.run_count ||
              got.ref_total !== want.ref_total || got.read_total !== want.read_total ||
              got.ins_total !== want.ins_total || got.final_result !== want.final_result)
          begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: op %h/%h count %0d/%0d ref %0d/%0d read %0d/%0d",
                       got.op_code, want.op_code, got.run_count, want.run_count,
                       got.ref_total, want.ref_total, got.read_total, want.read_total);
              $display("          ins %0d/%0d last %b/%b (actual/expected)",
                       got.ins_total, want.ins_total, got.final_result,
                       want.final_result);
            end
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic push_char(logic [7:0] c, logic eos);
    char_word_t w;
    w.ch  = c;
    w.eos = eos;
    pending_chars.insert(pending_chars.size(), w);
  endtask

  task automatic push_str(string s, logic term);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], term && (i == s.len() - 1));
    end
  endtask

  function automatic string count_text();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return "";
    if (r < 30) return "0";
    if (r < 75) return $sformatf("%0d", $urandom_range(1, 999));
    if (r < 80) return $sformatf("0%0d", $urandom_range(1, 99));
    if (r < 95) return $sformatf("%0d", $urandom);
    return "99999999999";
  endfunction

  // Mostly well-formed strings with random content, the rest raw noise.
  task automatic push_random_strings(int target);
    string      ops;
    string      bases;
    logic [7:0] prev;
    logic [7:0] op;
    int         start;
    int         kind;
    int         n;
    ops   = "MIDNSHPX=ACGT";
    bases = "ACGTM";
    start = pending_chars.size();
    while (pending_chars.size() - start < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        n    = $urandom_range(1, 6);
        prev = "M";
        for (int i = 0; i < n; i++) begin
          if (i > 0 && $urandom_range(0, 99) < 40) begin
            op = (letter_class(prev) == ChM) ? bases[$urandom_range(0, 4)] : prev;
          end else begin
            op = ops[$urandom_range(0, ops.len() - 1)];
          end
          push_str(count_text(), 1'b0);
          push_char(op, 1'b0);
          prev = op;
        end
        if ($urandom_range(0, 9) == 0) push_str($sformatf("%0d", $urandom_range(0, 99)), 1'b0);
        pending_chars[pending_chars.size() - 1].eos = 1'b1;
      end else if (kind < 83) begin
        push_str($sformatf("%0d", $urandom_range(0, 9999)), 1'b1);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          push_char(8'($urandom_range(0, 255)), i == n - 1);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || s_axis_tvalid || expected_runs.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    int tx_pct[4];
    int rx_pct[4];
    tx_pct = '{0, 59, 0, 6};
    rx_pct = '{0, 0, 59, 6};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Merge of base letters into one M run, then a lone deletion.
    push_str("0A3CD", 1'b1);
    // Digits only: no operation in the string.
    push_str("7", 1'b1);
    // Count one past the 32-bit maximum saturates.
    push_str("4294967296I", 1'b1);
    // Control bytes and a lowercase letter are operations too.
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b0);
    push_str("2m", 1'b1);
    // Trailing digits are dropped at the end of the string.
    push_str("M12", 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      push_random_strings(200);
      // Long receiver hold-off while the sender keeps offering characters.
      if (ph == 0) hold_reqs++;
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cpml_pkg.sv
hw/rtl/cigar_parse_merge_lengths_core.sv
test/tb_top.sv
